// File: rtl/core/rlesr_pkg.sv
// rlesr_pkg: shared types and constants of the sprite row run emitter
// depends on nothing; imported by rle_sprite_row_run_emitter
package rlesr_pkg;

  // line geometry
  localparam int LinePixels = 2048;
  localparam int LimitCap   = (LinePixels - 1 > 2047) ? 2047 : LinePixels - 1;

  // widths of row state and palette
  localparam int PosW      = 13;
  localparam int ColorW    = 16;
  localparam int PalDepth  = 16;
  localparam int PalIdxW   = 4;
  localparam int RunLenW   = 11;

  // input item codes
  typedef enum logic [1:0] {
    KIND_ROW_START = 2'd0,
    KIND_DATA      = 2'd1,
    KIND_PAL_WRITE = 2'd2
  } in_kind_e;

  // drawing token codes
  typedef enum logic [1:0] {
    TOK_SINGLE = 2'd0,
    TOK_PAIR   = 2'd1,
    TOK_RUN    = 2'd2
  } tok_kind_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          data_byte;
    logic [10:0]         skip_left;
    logic signed [11:0]  right_limit;
    logic [PalIdxW-1:0]  palette_index;
    logic [ColorW-1:0]   palette_color;
    logic                last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          token_kind;
    logic [ColorW-1:0]   pixel_color;
    logic [RunLenW-1:0]  run_length;
    logic                row_end;
  } out_item_t;

endpackage

// File: rtl/core/rlesr_ram.sv
// rlesr_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing; used for the palette store
module rlesr_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rle_sprite_row_run_emitter.sv
// rle_sprite_row_run_emitter: run-length sprite row decoder with palette lookup
// depends on rlesr_pkg and rlesr_ram
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// one item per cycle while in_stall_o is low; the transfer edge runs the row logic,
// issues the palette read and loads the read stage; the edge on which the read stage
// advances loads the output register with the palette data, so a token may wait
// in the read stage while the output is stalled; palette writes land at transfer
// reset clears row state to done and empties both stages; palette is unset
// in_stall_o rises only while the read stage holds a token that the stalled
// output register cannot take
module rle_sprite_row_run_emitter
  import rlesr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // row phase codes
  localparam logic [1:0] PhDone = 2'd0;
  localparam logic [1:0] PhSkip = 2'd1;
  localparam logic [1:0] PhDraw = 2'd2;

  // row state
  logic [1:0]              phase_q, phase_d;
  logic signed [PosW-1:0]  pos_q, pos_d;
  logic signed [PosW-1:0]  limit_q, limit_d;
  logic                    await_q, await_d;
  logic [PalIdxW-1:0]      held_idx_q, held_idx_d;

  // read stage: token waiting on palette data
  logic                    s1_valid_q;
  logic [1:0]              s1_kind_q;
  logic [RunLenW-1:0]      s1_len_q;
  logic                    s1_end_q;
  logic [ColorW-1:0]       pal_rdata;

  // output register
  logic                    out_valid_q;
  out_item_t               out_q;

  logic in_xfer, s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------
  // row logic on the incoming byte
  // ---------------------------------------------------------------
  logic                   emit;
  logic signed [PosW-1:0] emit_n;
  logic                   emit_end;
  logic [PalIdxW-1:0]     run_idx;
  logic signed [PosW-1:0] run_len;
  logic signed [PosW-1:0] pos_sum;
  logic signed [PosW-1:0] lim_gap;
  logic signed [PosW-1:0] skip_ext;
  logic signed [PosW-1:0] row_lim;
  logic                   have_run;
  logic                   is_data;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    limit_d    = limit_q;
    await_d    = await_q;
    held_idx_d = held_idx_q;
    emit_n     = '0;
    emit_end   = 1'b0;
    have_run   = 1'b0;
    run_idx    = in_data_i.data_byte[3:0];
    run_len    = PosW'(in_data_i.data_byte[7:4]);

    skip_ext = $signed({2'b00, in_data_i.skip_left});
    row_lim  = PosW'(in_data_i.right_limit) - skip_ext;
    is_data  = (in_data_i.kind == KIND_DATA) && (phase_q != PhDone);

    // length byte after a short code, or a packed code byte
    if (await_q) begin
      run_idx = held_idx_q;
      run_len = $signed({5'b00000, in_data_i.data_byte});
    end

    pos_sum = pos_q + run_len;
    lim_gap = limit_q - pos_q;

    if (in_data_i.kind == KIND_ROW_START) begin
      pos_d   = -skip_ext;
      limit_d = (row_lim > PosW'(LimitCap)) ? PosW'(LimitCap) : row_lim;
      await_d = 1'b0;
      phase_d = (in_data_i.skip_left != '0) ? PhSkip : PhDraw;
    end else if (is_data) begin
      if (await_q) begin
        await_d  = 1'b0;
        have_run = 1'b1;
      end else if (in_data_i.data_byte[7:4] == 4'h0) begin
        // short code: length follows unless the row ends here
        held_idx_d = in_data_i.data_byte[3:0];
        await_d    = !in_data_i.last_byte;
        if (in_data_i.last_byte) begin
          phase_d = PhDone;
        end
      end else begin
        have_run = 1'b1;
      end

      if (have_run) begin
        if (phase_q == PhSkip) begin
          pos_d = pos_sum;
          if (pos_sum >= 0) begin
            if (pos_sum >= limit_q) begin
              phase_d  = PhDone;
              emit_n   = limit_q;
              emit_end = 1'b1;
            end else begin
              phase_d  = in_data_i.last_byte ? PhDone : PhDraw;
              emit_n   = pos_sum;
              emit_end = in_data_i.last_byte;
            end
          end else if (in_data_i.last_byte) begin
            phase_d = PhDone;
          end
        end else begin
          // drawing: whole run fits, or clip at the limit
          if (pos_sum <= limit_q) begin
            pos_d    = pos_sum;
            emit_n   = run_len;
            emit_end = in_data_i.last_byte;
            if (in_data_i.last_byte) begin
              phase_d = PhDone;
            end
          end else begin
            phase_d  = PhDone;
            emit_n   = lim_gap;
            emit_end = 1'b1;
          end
        end
      end
    end

    // empty or negative visible runs make no token
    emit = have_run && (emit_n > 0);
  end

  // ---------------------------------------------------------------
  // palette store, written and read at transfer
  // ---------------------------------------------------------------
  rlesr_ram #(
    .Width (ColorW),
    .Depth (PalDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (in_data_i.kind == KIND_PAL_WRITE)),
    .waddr_i (in_data_i.palette_index),
    .wdata_i (in_data_i.palette_color),
    .re_i    (in_xfer && emit),
    .raddr_i (run_idx),
    .rdata_o (pal_rdata)
  );

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhDone;
      pos_q      <= '0;
      limit_q    <= '0;
      await_q    <= 1'b0;
      held_idx_q <= '0;
    end else if (in_xfer) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      limit_q    <= limit_d;
      await_q    <= await_d;
      held_idx_q <= held_idx_d;
    end
  end

  // read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= emit;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      s1_len_q <= emit_n[RunLenW-1:0];
      s1_end_q <= emit_end;
      if (emit_n == PosW'(1)) begin
        s1_kind_q <= TOK_SINGLE;
      end else if (emit_n == PosW'(2)) begin
        s1_kind_q <= TOK_PAIR;
      end else begin
        s1_kind_q <= TOK_RUN;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload, palette color joins here
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.token_kind  <= s1_kind_q;
      out_q.pixel_color <= pal_rdata;
      out_q.run_length  <= s1_len_q;
      out_q.row_end     <= s1_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  // a stuck read stage keeps its palette data
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(pal_rdata))
    else $error("read stage lost its token or palette data");

  // tokens always carry a visible length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.run_length != '0)
    else $error("token with zero run length");

  // token kind agrees with length
  a_kind_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.token_kind == TOK_SINGLE) == (out_data_o.run_length == 11'd1))
      && ((out_data_o.token_kind == TOK_PAIR) == (out_data_o.run_length == 11'd2)))
    else $error("token kind does not match run length");

  // bytes after the row has ended make no token
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (phase_q == PhDone) && (in_data_i.kind != KIND_ROW_START) |=> !s1_valid_q)
    else $error("token produced after row end");

  // input is held off only while the output side is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule
